// ===== rtl/hbump_pkg.sv =====
`timescale 1ns / 1ps

package hbump_pkg;

  // Line buffer depth and the fixed field widths.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W = 10;
  localparam int ROW_W = 16;
  localparam int PIX_W = 8;
  localparam int TEXEL_W = 32;
  localparam int WIDTH_W = 11;
  localparam int FMT_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH_V = WIDTH_W'(MAX_WIDTH);

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Three rotating line buffers: current row, one row back, two rows back.
  localparam int NUM_BANKS = 3;
  localparam int BANK_W = 2;

  localparam logic [FMT_W-1:0] FMT_V8U8 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_L6V5U5 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_X8L8V8U8 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [7:0] LUM_LAND = 8'd63;
  localparam logic [7:0] LUM_WATER = 8'd127;

  // One accepted pixel with its neighborhood from the row buffers and its
  // position flags.
  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] m1;
    logic [PIX_W-1:0] r1;
    logic [PIX_W-1:0] t2;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_ge1;
    logic             row_ge2;
    logic             last_row;
    logic             col0;
    logic             col_lt2;
    logic             col_last;
  } hbump_entry_t;

  function automatic logic [TEXEL_W-1:0] make_texel(
    input logic [PIX_W-1:0] l,
    input logic [PIX_W-1:0] m,
    input logic [PIX_W-1:0] rt,
    input logic [PIX_W-1:0] a,
    input logic [PIX_W-1:0] b,
    input logic [FMT_W-1:0] fmt
  );
    logic signed [9:0] sl;
    logic signed [9:0] sm;
    logic signed [9:0] sr;
    logic signed [9:0] sa;
    logic signed [9:0] sb;
    logic signed [9:0] du;
    logic signed [9:0] dv;
    logic signed [9:0] dm;
    logic [7:0] lum;
    logic [TEXEL_W-1:0] t;
    sl = signed'({2'b00, l});
    sm = signed'({2'b00, m});
    sr = signed'({2'b00, rt});
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    du = sl - sr;
    dv = sa - sb;
    dm = sm - sr;
    // In a valley the slope is the larger of l - m and m - r, so always l - m.
    if (sm < sl && sm < sr) begin
      du = sl - sm;
      if (du < dm) begin
        du = dm;
      end
    end
    lum = (m > 8'd1) ? LUM_LAND : LUM_WATER;
    case (fmt)
      FMT_V8U8: t = {16'd0, dv[7:0], du[7:0]};
      FMT_L6V5U5: t = {16'd0, lum[7:2], dv[7:3], du[7:3]};
      FMT_X8L8V8U8: t = {8'd0, lum, dv[7:0], du[7:0]};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/hbump_line_ram.sv =====
`timescale 1ns / 1ps

module hbump_line_ram
  import hbump_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic [COL_W-1:0] raddr_a,
  input  logic [COL_W-1:0] raddr_b,
  output logic [PIX_W-1:0] rdata_a,
  output logic [PIX_W-1:0] rdata_b
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/hbump_front.sv =====
`timescale 1ns / 1ps

module hbump_front
  import hbump_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [PIX_W-1:0]      height_sample,
  input  logic [Q_CNT_W-1:0]    q_count,
  output logic                  push,
  output hbump_entry_t          push_entry,
  output logic [FMT_W-1:0]      texel_format
);

  logic [WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  logic [COL_W-1:0]   col_count;
  logic [ROW_W-1:0]   row_count;
  logic [BANK_W-1:0]  bank_now;

  logic [WIDTH_W-1:0] w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic               restart;
  logic [COL_W-1:0]   c;
  logic [ROW_W-1:0]   r;
  logic               col_last;
  logic               last_row;
  logic               accept;
  logic [COL_W-1:0]   raddr_b;

  logic [PIX_W-1:0] rd_a [NUM_BANKS];
  logic [PIX_W-1:0] rd_b [NUM_BANKS];

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_x;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_row;
  logic               s1_row_ge1;
  logic               s1_row_ge2;
  logic               s1_last_row;
  logic               s1_col_last;
  logic [BANK_W-1:0]  s1_bank;
  logic [PIX_W-1:0]   one_a;
  logic [PIX_W-1:0]   one_b;
  logic [PIX_W-1:0]   two_a;

  // Out-of-range sizes are clamped.
  assign w_eff = (image_width == '0) ? WIDTH_W'(1) :
                 (image_width > MAX_WIDTH_V) ? MAX_WIDTH_V : image_width;
  assign h_eff = (image_height == '0) ? ROW_W'(1) : image_height;

  // A position beyond the current size starts a new image.
  assign restart = ({1'b0, col_count} >= w_eff) || (row_count >= h_eff);
  assign c = restart ? '0 : col_count;
  assign r = restart ? '0 : row_count;
  assign col_last = ({1'b0, c} == (w_eff - WIDTH_W'(1)));
  assign last_row = (r == (h_eff - ROW_W'(1)));

  // Room is reserved for the word already reading the line buffers.
  assign sample_stall = (q_count + Q_CNT_W'(s1_valid)) >= Q_CNT_W'(Q_DEPTH);
  assign accept = sample_valid && !sample_stall;
  assign raddr_b = col_last ? c : c + COL_W'(1);

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    hbump_line_ram u_ram (
      .clk     (clk),
      .we      (accept && (bank_now == BANK_W'(k))),
      .waddr   (c),
      .wdata   (height_sample),
      .raddr_a (c),
      .raddr_b (raddr_b),
      .rdata_a (rd_a[k]),
      .rdata_b (rd_b[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format <= FMT_L6V5U5;
      image_width <= WIDTH_W'(256);
      image_height <= ROW_W'(256);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEXEL_FORMAT: texel_format <= cfg_data[FMT_W-1:0];
        REG_IMAGE_WIDTH: image_width <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      bank_now <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (col_last) begin
          col_count <= '0;
          if (last_row) begin
            row_count <= '0;
          end else begin
            row_count <= r + ROW_W'(1);
            bank_now <= (bank_now == BANK_W'(NUM_BANKS - 1)) ? '0 : bank_now + BANK_W'(1);
          end
        end else begin
          col_count <= c + COL_W'(1);
          row_count <= r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x <= height_sample;
      s1_col <= c;
      s1_row <= r;
      s1_row_ge1 <= (r != '0);
      s1_row_ge2 <= (r >= ROW_W'(2));
      s1_last_row <= last_row;
      s1_col_last <= col_last;
      s1_bank <= bank_now;
    end
  end

  // The bank one back is the one before the current bank, the bank two
  // back the one after it.
  always_comb begin
    case (s1_bank)
      2'd0: begin
        one_a = rd_a[2];
        one_b = rd_b[2];
        two_a = rd_a[1];
      end
      2'd1: begin
        one_a = rd_a[0];
        one_b = rd_b[0];
        two_a = rd_a[2];
      end
      default: begin
        one_a = rd_a[1];
        one_b = rd_b[1];
        two_a = rd_a[0];
      end
    endcase
  end

  assign push = s1_valid;

  always_comb begin
    push_entry.x = s1_x;
    push_entry.m1 = one_a;
    push_entry.r1 = one_b;
    push_entry.t2 = two_a;
    push_entry.col = s1_col;
    push_entry.row = s1_row;
    push_entry.row_ge1 = s1_row_ge1;
    push_entry.row_ge2 = s1_row_ge2;
    push_entry.last_row = s1_last_row;
    push_entry.col0 = (s1_col == '0);
    push_entry.col_lt2 = (s1_col < COL_W'(2));
    push_entry.col_last = s1_col_last;
  end

endmodule

// ===== rtl/hbump_queue.sv =====
`timescale 1ns / 1ps

module hbump_queue
  import hbump_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hbump_entry_t       push_entry,
  input  logic               pop,
  output hbump_entry_t       head,
  output logic               empty,
  output logic [Q_CNT_W-1:0] count
);

  hbump_entry_t       slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  assign head = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/hbump_back.sv =====
`timescale 1ns / 1ps

module hbump_back
  import hbump_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [FMT_W-1:0]   texel_format,
  input  logic               q_empty,
  input  hbump_entry_t       head,
  output logic               pop,
  output logic               texel_valid,
  input  logic               texel_stall,
  output logic [TEXEL_W-1:0] bump_texel,
  output logic [COL_W-1:0]   texel_col,
  output logic [ROW_W-1:0]   texel_row,
  output logic               last_of_run,
  output logic               image_done
);

  // Bit 0: texel of the row above. Bit 1: left neighbor on the last row.
  // Bit 2: final texel of the image.
  logic [2:0] need;
  logic [2:0] done_mask;
  logic [2:0] remaining;
  logic [2:0] sel;
  logic       is_last;
  logic       out_free;
  logic       step;
  logic       emit;

  logic [PIX_W-1:0] prev_m;
  logic [PIX_W-1:0] prev_x1;
  logic [PIX_W-1:0] prev_x2;

  logic [PIX_W-1:0] op_l;
  logic [PIX_W-1:0] op_m;
  logic [PIX_W-1:0] op_r;
  logic [PIX_W-1:0] op_a;
  logic [PIX_W-1:0] op_b;
  logic [COL_W-1:0] op_col;
  logic [ROW_W-1:0] op_row;

  assign need = {head.last_row & head.col_last,
                 head.last_row & ~head.col0,
                 head.row_ge1};
  assign remaining = need & ~done_mask;
  assign sel = {remaining[2] & ~remaining[1] & ~remaining[0],
                remaining[1] & ~remaining[0],
                remaining[0]};
  assign is_last = ((remaining & ~sel) == 3'b000);

  assign out_free = !texel_valid || !texel_stall;
  // A word that yields nothing is retired without waiting for the output.
  assign step = !q_empty && ((remaining == 3'b000) || out_free);
  assign emit = step && (remaining != 3'b000);
  assign pop = step && is_last;

  always_comb begin
    if (sel[0]) begin
      op_l = head.col0 ? head.m1 : prev_m;
      op_m = head.m1;
      op_r = head.r1;
      op_a = head.row_ge2 ? head.t2 : head.m1;
      op_b = head.x;
      op_col = head.col;
      op_row = head.row - ROW_W'(1);
    end else if (sel[1]) begin
      op_l = head.col_lt2 ? prev_x1 : prev_x2;
      op_m = prev_x1;
      op_r = head.x;
      op_a = head.row_ge1 ? prev_m : prev_x1;
      op_b = prev_x1;
      op_col = head.col - COL_W'(1);
      op_row = head.row;
    end else begin
      op_l = head.col0 ? head.x : prev_x1;
      op_m = head.x;
      op_r = head.x;
      op_a = head.row_ge1 ? head.m1 : head.x;
      op_b = head.x;
      op_col = head.col;
      op_row = head.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
      texel_valid <= 1'b0;
    end else begin
      if (step) begin
        done_mask <= pop ? 3'b000 : (done_mask | sel);
      end
      if (out_free) begin
        texel_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prev_m <= head.m1;
      prev_x1 <= head.x;
      prev_x2 <= prev_x1;
    end
    if (emit) begin
      bump_texel <= make_texel(op_l, op_m, op_r, op_a, op_b, texel_format);
      texel_col <= op_col;
      texel_row <= op_row;
      last_of_run <= is_last;
      image_done <= sel[2];
    end
  end

endmodule

// ===== rtl/height_to_bump_texel_stream.sv =====
`timescale 1ns / 1ps

// Height map to bump texel stream.
// Height bytes enter in raster order on the sample channel (sample_valid,
// sample_stall, height_sample); one word is taken at each edge with valid
// high and stall low. Bump texels leave on the texel channel (texel_valid,
// texel_stall and the payload ports) as du/dv with luminance, packed per
// texel_format. A texel needs the row below it, so the pixel at (row, col)
// releases texel (row-1, col); on the last row a pixel also releases its
// left neighbor and the final pixel the last texel, up to three words.
// The configuration port (cfg_write, cfg_index, cfg_data) takes register
// writes; write it only while the block is idle. A pixel passes the front's
// stage registers and a queue slot before its texels reach the output register.
// Throughput: one pixel per cycle while sample_stall is low; on the last row
// the texels of a pixel leave in turn through the back end's single output register.
// The front reads three rotating line buffers, each with one write port and
// two registered read ports, and feeds a four-word queue; the back end
// emits from it. Reset restores the register defaults and starts a new
// image at row 0, column 0. When the receiver stalls, the texel holds,
// the queue fills, and sample_stall rises once it has no room left.

module height_to_bump_texel_stream
  import hbump_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [PIX_W-1:0]      height_sample,
  output logic                  texel_valid,
  input  logic                  texel_stall,
  output logic [TEXEL_W-1:0]    bump_texel,
  output logic [COL_W-1:0]      texel_col,
  output logic [ROW_W-1:0]      texel_row,
  output logic                  last_of_run,
  output logic                  image_done
);

  logic               push;
  hbump_entry_t       push_entry;
  logic               pop;
  hbump_entry_t       head;
  logic               q_empty;
  logic [Q_CNT_W-1:0] q_count;
  logic [FMT_W-1:0]   texel_format;

  // Front: configuration, position counters and line buffers.
  hbump_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .height_sample (height_sample),
    .q_count       (q_count),
    .push          (push),
    .push_entry    (push_entry),
    .texel_format  (texel_format)
  );

  // The queue lets the front keep taking pixels while the back end waits
  // on a stalled receiver or works through a last-row burst.
  hbump_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .count      (q_count)
  );

  // Back end: forms up to three texels per pixel, one per cycle while the receiver does not stall.
  hbump_back u_back (
    .clk          (clk),
    .rst          (rst),
    .texel_format (texel_format),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .texel_valid  (texel_valid),
    .texel_stall  (texel_stall),
    .bump_texel   (bump_texel),
    .texel_col    (texel_col),
    .texel_row    (texel_row),
    .last_of_run  (last_of_run),
    .image_done   (image_done)
  );

endmodule
